>>> rtl/core/rolp_pkg.sv
// Shared constants and register indexes for the record-once loop player.
`default_nettype none

package rolp_pkg;

   // Number of audio channels in one frame; each channel gets its own lane.
   localparam int CHANNELS = 2;

   // Configuration port widths and register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 19;
   localparam int LENGTH_BITS    = 19;
   localparam int MIX_BITS       = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOOP_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIX_LEVEL   = 2'd1;

   // Reset values and the Q1.15 unity mix.
   localparam logic [LENGTH_BITS-1:0] LOOP_LENGTH_RESET = 19'd48000;
   localparam logic [MIX_BITS-1:0]    MIX_LEVEL_RESET   = 16'd16384;
   localparam logic [MIX_BITS-1:0]    MIX_ONE           = 16'd32768;

   // Fraction bits of the mix level.
   localparam int MIX_SHIFT = 15;

endpackage

`default_nettype wire

>>> rtl/core/record_once_loop_player.sv
// Record-once stereo loop player top level: lanes, loop store and handshakes.
//
//   Channel | Direction | Handshake              | Payload
//   req_    | in        | req_valid / req_stall  | req_in_left, req_in_right, req_rearm
//   rsp_    | out       | rsp_valid / rsp_stall  | rsp_out_left, rsp_out_right
//   csr_    | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// One frame is accepted per cycle unless req_stall is high. Each passes three register
// stages (loop store read, multiply, mix and floor) before it is offered on rsp_.
// The loop store is a single RAM with one write and one registered read port.
// Reset clears position, sets recording, reloads registers; the store is not cleared.
// A stalled output holds its item; upstream stages keep filling until all are full.
`default_nettype none

module record_once_loop_player #(
   parameter int MAX_LOOP_FRAMES = 262144,
   parameter int SAMPLE_BITS     = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [SAMPLE_BITS-1:0]              req_in_left,
   input  wire logic [SAMPLE_BITS-1:0]              req_in_right,
   input  wire logic                                req_rearm,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [SAMPLE_BITS-1:0]              rsp_out_left,
   output logic      [SAMPLE_BITS-1:0]              rsp_out_right,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rolp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rolp_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import rolp_pkg::*;

   localparam int PW = $clog2(MAX_LOOP_FRAMES);
   localparam int FW = CHANNELS * SAMPLE_BITS;

   logic [LENGTH_BITS-1:0] length_ff;
   logic [MIX_BITS-1:0]    mix_ff;
   logic                   v1_ff, v2_ff, v3_ff;
   logic                   rec1_ff;
   logic                   en1, en2, en3;
   logic                   accept;
   logic [PW-1:0]          item_pos;
   logic                   item_rec;
   logic                   rec_state;
   logic [FW-1:0]          frame;
   logic [FW-1:0]          rd_frame;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] lane_out;

   // Each stage moves on when the one after it is empty or moving.
   assign en3       = !v3_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LOOP_LENGTH_RESET;
         mix_ff    <= MIX_LEVEL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LOOP_LENGTH: length_ff <= csr_data[LENGTH_BITS-1:0];
            CSR_MIX_LEVEL: begin
               mix_ff <= (csr_data[MIX_BITS-1:0] > MIX_ONE) ? MIX_ONE
                                                            : csr_data[MIX_BITS-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= accept;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         rec1_ff <= item_rec;
      end
   end

   rolp_seq #(
      .MAX_LOOP_FRAMES(MAX_LOOP_FRAMES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rearm      (req_rearm),
      .loop_length(length_ff),
      .item_pos   (item_pos),
      .item_rec   (item_rec),
      .rec_state  (rec_state)
   );

   assign frame = {req_in_right, req_in_left};

   rolp_ram #(
      .WIDTH(FW),
      .DEPTH(MAX_LOOP_FRAMES)
   ) u_store (
      .clock  (clock),
      .wr_en  (accept && item_rec),
      .wr_addr(item_pos),
      .wr_data(frame),
      .rd_en  (en1),
      .rd_addr(item_pos),
      .rd_data(rd_frame)
   );

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      rolp_lane #(
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
         .clock      (clock),
         .en1        (en1),
         .en2        (en2),
         .en3        (en3),
         .dry_sample (frame[c*SAMPLE_BITS +: SAMPLE_BITS]),
         .rec1       (rec1_ff),
         .loop_sample(rd_frame[c*SAMPLE_BITS +: SAMPLE_BITS]),
         .mix        (mix_ff),
         .out_sample (lane_out[c])
      );
   end

   assign rsp_valid     = v3_ff;
   assign rsp_out_left  = lane_out[0];
   assign rsp_out_right = lane_out[1];

`ifndef SYNTHESIS
   // Input is held back only when every stage holds an item.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff))
      else $error("input stalled while the pipeline has room");

   // A new result appears only from an item in the multiply stage.
   a_result_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v2_ff))
      else $error("result appeared without an item behind it");

   // Recording resumes only through an accepted rearm item.
   a_rec_only_on_rearm: assert property (@(posedge clock) disable iff (reset)
      $rose(rec_state) |-> $past(accept && req_rearm))
      else $error("recording restarted without a rearm");
`endif

endmodule

`default_nettype wire

>>> rtl/core/rolp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module rolp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 262144
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/rolp_seq.sv
// Loop position and record/playback sequencer.
`default_nettype none

module rolp_seq #(
   parameter int MAX_LOOP_FRAMES = 262144
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 accept,
   input  wire logic                                 rearm,
   input  wire logic [rolp_pkg::LENGTH_BITS-1:0]     loop_length,
   output logic      [$clog2(MAX_LOOP_FRAMES)-1:0]   item_pos,
   output logic                                      item_rec,
   output logic                                      rec_state
);
   import rolp_pkg::*;

   localparam int PW = $clog2(MAX_LOOP_FRAMES);
   localparam int AW = $clog2(MAX_LOOP_FRAMES + 1);
   localparam int LW = (AW > LENGTH_BITS) ? AW : LENGTH_BITS;
   localparam int unsigned ACT_RESET =
      (int'(LOOP_LENGTH_RESET) > MAX_LOOP_FRAMES) ? MAX_LOOP_FRAMES
                                                  : int'(LOOP_LENGTH_RESET);

   logic [PW-1:0] pos_ff, pos_in;
   logic          rec_ff, rec_in;
   logic [AW-1:0] active_ff, active_in;
   logic [AW-1:0] act_eff;
   logic [LW-1:0] len_ext;
   logic [LW-1:0] len_clamped;
   logic [AW-1:0] pos_next;

   // A length of zero acts as one; anything above the store depth is cut to it.
   always_comb begin
      len_ext = LW'(loop_length);
      if (len_ext == '0) begin
         len_clamped = LW'(1);
      end else if (len_ext > LW'(MAX_LOOP_FRAMES)) begin
         len_clamped = LW'(MAX_LOOP_FRAMES);
      end else begin
         len_clamped = len_ext;
      end
   end

   always_comb begin
      if (rearm) begin
         item_pos = '0;
         item_rec = 1'b1;
         act_eff  = AW'(len_clamped);
      end else begin
         item_pos = pos_ff;
         item_rec = rec_ff;
         act_eff  = active_ff;
      end
      pos_next  = AW'(item_pos) + AW'(1);
      pos_in    = pos_ff;
      rec_in    = rec_ff;
      active_in = active_ff;
      if (accept) begin
         active_in = act_eff;
         if (pos_next >= act_eff) begin
            pos_in = '0;
            rec_in = 1'b0;
         end else begin
            pos_in = pos_next[PW-1:0];
            rec_in = item_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         rec_ff    <= 1'b1;
         active_ff <= AW'(ACT_RESET);
      end else begin
         pos_ff    <= pos_in;
         rec_ff    <= rec_in;
         active_ff <= active_in;
      end
   end

   assign rec_state = rec_ff;

endmodule

`default_nettype wire

>>> rtl/core/rolp_lane.sv
// One channel lane: loop/dry select, wet-dry multiply, and output mix.
`default_nettype none

module rolp_lane #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          en1,
   input  wire logic                          en2,
   input  wire logic                          en3,
   input  wire logic [SAMPLE_BITS-1:0]        dry_sample,
   input  wire logic                          rec1,
   input  wire logic [SAMPLE_BITS-1:0]        loop_sample,
   input  wire logic [rolp_pkg::MIX_BITS-1:0] mix,
   output logic      [SAMPLE_BITS-1:0]        out_sample
);
   import rolp_pkg::*;

   localparam int DW   = SAMPLE_BITS + 1;
   localparam int MW   = MIX_BITS + 1;
   localparam int PRW  = DW + MW;
   localparam int SUMW = PRW + 1;

   logic signed [SAMPLE_BITS-1:0] dry1_ff;
   logic signed [SAMPLE_BITS-1:0] dry2_ff;
   logic signed [PRW-1:0]         prod2_ff;
   logic        [SAMPLE_BITS-1:0] out_ff;
   logic signed [SAMPLE_BITS-1:0] wet;
   logic signed [DW-1:0]          diff;
   logic signed [MW-1:0]          mix_s;
   logic signed [PRW-1:0]         prod_in;
   logic signed [SUMW-1:0]        sum;

   // out = dry + (wet - dry) * mix, computed as a Q1.15 sum and floored.
   always_comb begin
      wet     = rec1 ? dry1_ff : $signed(loop_sample);
      diff    = DW'(wet) - DW'(dry1_ff);
      mix_s   = $signed({1'b0, mix});
      prod_in = PRW'(diff) * PRW'(mix_s);
      sum     = (SUMW'(dry2_ff) <<< MIX_SHIFT) + SUMW'(prod2_ff);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         dry1_ff <= $signed(dry_sample);
      end
      if (en2) begin
         dry2_ff  <= dry1_ff;
         prod2_ff <= prod_in;
      end
      if (en3) begin
         out_ff <= sum[SAMPLE_BITS+MIX_SHIFT-1:MIX_SHIFT];
      end
   end

   assign out_sample = out_ff;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the record-once loop player with a tracking model of the loop store.
`timescale 1ns / 1ps

module tb;
   import rolp_pkg::*;

   localparam int LOOP_FRAMES = 262144;
   localparam int SAMPLE_W    = 24;
   localparam int CYCLE_LIMIT = 400000;

   // Indexes with no register behind them; writes to them must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_B = 2'd3;

   class loop_mix_tracker;
      logic [2*SAMPLE_W-1:0] recorded [int];
      logic [2*SAMPLE_W-1:0] expected_mix [$];
      int unsigned           position;
      bit                    recording;
      int unsigned           active_len;
      logic [LENGTH_BITS-1:0] length_reg;
      logic [MIX_BITS-1:0]    mix_reg;
      int                    errors;

      function new();
         position   = 0;
         recording  = 1'b1;
         length_reg = LOOP_LENGTH_RESET;
         mix_reg    = MIX_LEVEL_RESET;
         active_len = clamp_length(LOOP_LENGTH_RESET);
         errors     = 0;
      endfunction

      function int unsigned clamp_length(logic [LENGTH_BITS-1:0] v);
         if (v == 0) return 1;
         if (v > LOOP_FRAMES) return LOOP_FRAMES;
         return 32'(v);
      endfunction

      function int pending();
         return expected_mix.size();
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] idx,
                                   logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_LOOP_LENGTH: length_reg = data[LENGTH_BITS-1:0];
            CSR_MIX_LEVEL:   mix_reg = data[MIX_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Convex blend of dry and wet, floored by the arithmetic shift.
      function logic [SAMPLE_W-1:0] blend(logic [SAMPLE_W-1:0] dry,
                                          logic [SAMPLE_W-1:0] wet,
                                          int unsigned mix);
         longint d, w, m, s;
         d = $signed(dry);
         w = $signed(wet);
         m = mix;
         s = d * (longint'(MIX_ONE) - m) + w * m;
         s = s >>> MIX_SHIFT;
         return s[SAMPLE_W-1:0];
      endfunction

      function void accept_frame(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right,
                                 logic rearm);
         logic [2*SAMPLE_W-1:0] wet_pair;
         int unsigned mix, slot;
         mix = (mix_reg > MIX_ONE) ? 32'(MIX_ONE) : 32'(mix_reg);
         if (rearm) begin
            position   = 0;
            recording  = 1'b1;
            active_len = clamp_length(length_reg);
         end
         slot = position;
         if (recording) begin
            recorded[slot] = {left, right};
            wet_pair = {left, right};
         end else begin
            wet_pair = recorded.exists(slot) ? recorded[slot] : '0;
         end
         slot++;
         if (slot >= active_len) begin
            slot = 0;
            recording = 1'b0;
         end
         position = slot;
         expected_mix.push_back({blend(left, wet_pair[2*SAMPLE_W-1:SAMPLE_W], mix),
                                 blend(right, wet_pair[SAMPLE_W-1:0], mix)});
      endfunction

      function void check_output(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right);
         logic [2*SAMPLE_W-1:0] exp_pair;
         if (expected_mix.size() == 0) begin
            $display("%0t unexpected output item: expected none actual %h %h",
                     $time, left, right);
            errors++;
            return;
         end
         exp_pair = expected_mix.pop_front();
         if (exp_pair[2*SAMPLE_W-1:SAMPLE_W] !== left) begin
            $display("%0t out_left mismatch: expected %h actual %h",
                     $time, exp_pair[2*SAMPLE_W-1:SAMPLE_W], left);
            errors++;
         end
         if (exp_pair[SAMPLE_W-1:0] !== right) begin
            $display("%0t out_right mismatch: expected %h actual %h",
                     $time, exp_pair[SAMPLE_W-1:0], right);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [SAMPLE_W-1:0] req_in_left = '0;
   logic [SAMPLE_W-1:0] req_in_right = '0;
   logic req_rearm = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0] rsp_out_left;
   logic [SAMPLE_W-1:0] rsp_out_right;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   loop_mix_tracker board = new();
   int frames_sent = 0;

   record_once_loop_player #(
      .MAX_LOOP_FRAMES(LOOP_FRAMES),
      .SAMPLE_BITS(SAMPLE_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_left(req_in_left),
      .req_in_right(req_in_right),
      .req_rearm(req_rearm),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_left(rsp_out_left),
      .rsp_out_right(rsp_out_right),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) board.write_register(csr_index, csr_data);
      if (!reset && req_valid && !req_stall)
         board.accept_frame(req_in_left, req_in_right, req_rearm);
      if (!reset && rsp_valid && !rsp_stall) board.check_output(rsp_out_left, rsp_out_right);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("record_once_loop_player verification failed");
      $finish;
   end

   // Output side: random stalls, a quiet stretch, and now and then a long hold-off
   // so that the pipeline backs up into the input.
   initial begin : drain_side
      int hold, drained;
      drained = 0;
      while (reset) @(posedge clock);
      forever begin
         if (drained % 500 == 250) hold = 60;
         else if (drained >= 900 && drained < 1100) hold = 0;
         else hold = $urandom_range(0, 3);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         drained++;
      end
   end

   // Leaves valid high after the item is taken; callers lower it at phase end.
   task automatic send_frame(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right,
                             input logic rearm);
      int gap;
      gap = (frames_sent >= 400 && frames_sent < 550) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_left  <= left;
      req_in_right <= right;
      req_rearm    <= rearm;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      frames_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Drain the block completely, then rewrite the registers.
   task automatic reconfigure(input logic [CSR_DATA_BITS-1:0] length_val,
                              input logic [CSR_DATA_BITS-1:0] mix_val, input bit extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      write_reg(CSR_LOOP_LENGTH, length_val);
      write_reg(CSR_MIX_LEVEL, mix_val);
      if (extra) begin
         write_reg(CSR_UNUSED_A, CSR_DATA_BITS'($urandom));
         write_reg(CSR_UNUSED_B, CSR_DATA_BITS'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 11))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int items_left, count, k;
      bit lead_rearm;
      logic [CSR_DATA_BITS-1:0] len_pick, mix_pick;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: half mix, long loop, still recording.
      send_frame(24'h7FFFFF, 24'h800000, 1'b0);
      send_frame(24'h800000, 24'h7FFFFF, 1'b0);
      send_frame(24'h000000, 24'hFFFFFF, 1'b0);
      send_frame(24'h7FFFFF, 24'h7FFFFF, 1'b1);
      send_frame(24'h800000, 24'h800000, 1'b0);

      // A zero length acts as one frame; full mix plays only the loop.
      reconfigure(19'd0, CSR_DATA_BITS'(MIX_ONE), 1'b0);
      send_frame(24'h123456, 24'h800000, 1'b1);
      send_frame(24'h7FFFFF, 24'h7FFFFF, 1'b0);
      send_frame(24'h000000, 24'h000000, 1'b0);

      // Mix above unity is clamped. A length change without rearm is held.
      reconfigure(19'd3, 19'h7FFFF, 1'b0);
      send_frame(24'h7FFFFF, 24'h800000, 1'b1);
      send_frame(24'h800000, 24'h7FFFFF, 1'b0);
      send_frame(24'hABCDEF, 24'h543210, 1'b0);
      send_frame(24'h000000, 24'h000000, 1'b0);
      reconfigure(19'd5, 19'h7FFFF, 1'b0);
      send_frame(24'h111111, 24'hEEEEEE, 1'b0);
      send_frame(24'hFFFFFF, 24'h000001, 1'b0);
      send_frame(24'h7FFFFF, 24'h7FFFFF, 1'b0);
      send_frame(24'h800000, 24'h800000, 1'b1);

      // Length above the store depth is clamped; unused indexes are ignored.
      reconfigure(19'h7FFFF, 19'd0, 1'b1);
      send_frame(24'h7FFFFF, 24'h800000, 1'b1);
      send_frame(24'h800000, 24'h7FFFFF, 1'b0);

      reconfigure(19'd2, 19'd1, 1'b0);
      send_frame(24'h7FFFFF, 24'h800000, 1'b1);
      send_frame(24'h800000, 24'h7FFFFF, 1'b0);
      send_frame(24'h000000, 24'h000000, 1'b0);
      send_frame(24'hFFFFFF, 24'h000001, 1'b0);
      reconfigure(19'd2, 19'd32767, 1'b0);
      send_frame(24'h7FFFFF, 24'h7FFFFF, 1'b0);
      send_frame(24'h800000, 24'h800000, 1'b0);

      items_left = 1650;
      while (items_left > 0) begin
         case ($urandom_range(0, 15))
            0: len_pick = 19'd0;
            1: len_pick = CSR_DATA_BITS'(LOOP_FRAMES);
            2: len_pick = 19'h7FFFF;
            3, 4: len_pick = CSR_DATA_BITS'($urandom_range(41, 300));
            default: len_pick = CSR_DATA_BITS'($urandom_range(1, 40));
         endcase
         case ($urandom_range(0, 7))
            0: mix_pick = 19'd0;
            1: mix_pick = CSR_DATA_BITS'(MIX_ONE);
            2: mix_pick = CSR_DATA_BITS'($urandom_range(0, 19'h7FFFF));
            3: mix_pick = 19'd1;
            default: mix_pick = CSR_DATA_BITS'($urandom_range(0, MIX_ONE));
         endcase
         reconfigure(len_pick, mix_pick, $urandom_range(0, 3) == 0);
         lead_rearm = ($urandom_range(0, 3) != 0);
         count = $urandom_range(40, 140);
         if (count > items_left) count = items_left;
         for (k = 0; k < count; k++) begin
            send_frame(random_sample(), random_sample(),
                       (k == 0 && lead_rearm) || $urandom_range(0, 63) == 0);
         end
         items_left -= count;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0)
         $display("record_once_loop_player verification clean");
      else
         $display("record_once_loop_player verification failed");
      $finish;
   end

endmodule
